[src/mre_pkg.sv]
// Shared types, character codes and decimal helpers for the mouse report encoder.
`default_nettype none

package mre_pkg;

    localparam int COORD_FIELD_W = 12;
    localparam int MRE_COORD_BITS = 12;
    localparam int CFG_IDX_W = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SGR_FORMAT    = 2'd1;

    // Event kinds
    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_MOTION  = 2'd2;

    // Characters of the report
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_M_UP   = 8'h4D;
    localparam logic [7:0] CH_M_LOW  = 8'h6D;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    typedef struct packed {
        logic [1:0]               event_kind;
        logic [7:0]               button_code;
        logic [COORD_FIELD_W-1:0] column;
        logic [COORD_FIELD_W-1:0] line;
        logic                     shift_held;
        logic                     alt_held;
        logic                     ctrl_held;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } out_item_t;

    // Four decimal digits, index 3 the most significant
    typedef logic [3:0][3:0] digs_t;

    // One classified and converted report waiting for the emitter
    typedef struct packed {
        logic        release_evt;
        logic        sgr;
        logic [8:0]  code;
        logic [12:0] cx;
        logic [12:0] cy;
        digs_t       code_dig;
        digs_t       cx_dig;
        digs_t       cy_dig;
    } job_t;

    // Decimal digit of val at the given place; val must be below ten times the place.
    function automatic logic [3:0] dec_digit(input logic [12:0] val, input int unsigned unit);
        logic [3:0] d;
        d = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (32'(val) >= 32'(k) * unit) begin
                d = 4'(k);
            end
        end
        return d;
    endfunction

    function automatic logic [12:0] dec_rem(input logic [12:0] val, input int unsigned unit);
        logic [3:0] d;
        d = dec_digit(val, unit);
        return val - 13'(32'(d) * unit);
    endfunction

    function automatic logic [7:0] sat_byte(input logic [12:0] val);
        logic [13:0] s;
        s = {1'b0, val} + 14'd32;
        return (s > 14'd255) ? 8'hFF : s[7:0];
    endfunction

    // Position of the leading non-zero digit; a value of zero still shows one digit.
    function automatic logic [1:0] top_digit(input digs_t d);
        logic [1:0] idx;
        if (d[3] != 4'd0) begin
            idx = 2'd3;
        end else if (d[2] != 4'd0) begin
            idx = 2'd2;
        end else if (d[1] != 4'd0) begin
            idx = 2'd1;
        end else begin
            idx = 2'd0;
        end
        return idx;
    endfunction

    function automatic logic [7:0] ascii_digit(input logic [3:0] d);
        return CH_ZERO | {4'b0000, d};
    endfunction

endpackage

`default_nettype wire

[src/mouse_report_encoder_core.sv]
// Top level of the mouse report encoder: configuration registers and the three stages.
//
// Mouse events are pushed into the input queue port (push, full, in_item) and the
// report comes out one byte per item on the output queue port (empty, pop, out_item),
// with last_byte marking the final byte of each report. Two registers on the cfg_*
// write port select whether reporting is on and whether SGR or legacy format is used;
// cfg_ready is always high. Writes should only be made while no report is in flight.
// An event passes the front end and the queue before its first byte reaches out_item.
// The emitter sets the sustained rate, sending one byte per cycle while the receiver
// keeps popping; an SGR report has 9 to 17 bytes and a legacy report 6. The next
// report follows the previous one without a gap. The front end converts numbers to
// decimal in a four-stage pipeline and can take an event every cycle until its
// two-entry hand-over queue fills. When the receiver stops popping, the held byte
// stays on out_item, the queue fills and full is raised. Events pushed while
// reporting is off produce nothing. Reset clears both registers (reporting off,
// legacy format) and drops any report in progress.
`default_nettype none

module mouse_report_encoder_core #(
    parameter int COORD_BITS = mre_pkg::MRE_COORD_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  mre_pkg::in_item_t                in_item,
    output logic                             empty,
    input  logic                             pop,
    output mre_pkg::out_item_t               out_item,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mre_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic                             cfg_data
);
    import mre_pkg::*;

    logic report_enable_reg;
    logic sgr_format_reg;
    logic job_valid;
    job_t front_job;
    job_t head;
    logic q_full, q_empty, q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_enable_reg <= 1'b0;
            sgr_format_reg    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_REPORT_ENABLE: report_enable_reg <= cfg_data;
                REG_SGR_FORMAT:    sgr_format_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    mre_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .in_item       (in_item),
        .report_enable (report_enable_reg),
        .sgr_format    (sgr_format_reg),
        .job_valid     (job_valid),
        .job           (front_job),
        .q_full        (q_full)
    );

    mre_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (job_valid),
        .wr_job   (front_job),
        .q_full   (q_full),
        .q_empty  (q_empty),
        .head     (head),
        .rd_pop   (q_pop)
    );

    mre_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .head     (head),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

endmodule

`default_nettype wire

[src/mre_front.sv]
// Front end: accepts mouse events, builds the button code and converts the numbers to decimal.
`default_nettype none

module mre_front #(
    parameter int COORD_BITS = mre_pkg::MRE_COORD_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  mre_pkg::in_item_t in_item,
    input  logic             report_enable,
    input  logic             sgr_format,
    output logic             job_valid,
    output mre_pkg::job_t    job,
    input  logic             q_full
);
    import mre_pkg::*;

    localparam int EFF_BITS = (COORD_BITS < COORD_FIELD_W) ? COORD_BITS : COORD_FIELD_W;
    localparam logic [COORD_FIELD_W-1:0] CMASK = COORD_FIELD_W'((1 << EFF_BITS) - 1);

    logic        adv;
    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    job_t        s1_job_next;
    job_t        s1_job_reg, s2_job_reg, s3_job_reg, s4_job_reg;
    job_t        s2_job_next, s3_job_next, s4_job_next;
    logic [6:0]  code_rem2_reg, code_rem2_next;
    logic [9:0]  cx_rem2_reg, cx_rem2_next, cy_rem2_reg, cy_rem2_next;
    logic [6:0]  cx_rem3_reg, cx_rem3_next, cy_rem3_reg, cy_rem3_next;
    logic [8:0]  code_sum;

    // The whole pipeline moves together; it stops only when its last stage cannot hand over.
    assign adv       = !s4_valid_reg || !q_full;
    assign full      = !adv;
    assign job_valid = s4_valid_reg;
    assign job       = s4_job_reg;

    always_comb
    begin
        code_sum = {1'b0, in_item.button_code}
                 + ((in_item.event_kind == KIND_MOTION) ? 9'd32 : 9'd0)
                 + (in_item.shift_held ? 9'd4 : 9'd0)
                 + (in_item.alt_held ? 9'd8 : 9'd0)
                 + (in_item.ctrl_held ? 9'd16 : 9'd0);
        s1_job_next             = '0;
        s1_job_next.release_evt = (in_item.event_kind == KIND_RELEASE);
        s1_job_next.sgr         = sgr_format;
        s1_job_next.code        = code_sum;
        s1_job_next.cx          = {1'b0, in_item.column & CMASK} + 13'd1;
        s1_job_next.cy          = {1'b0, in_item.line & CMASK} + 13'd1;
    end

    always_comb
    begin
        s2_job_next             = s1_job_reg;
        s2_job_next.code_dig[3] = 4'd0;
        s2_job_next.code_dig[2] = dec_digit(13'(s1_job_reg.code), 100);
        s2_job_next.cx_dig[3]   = dec_digit(s1_job_reg.cx, 1000);
        s2_job_next.cy_dig[3]   = dec_digit(s1_job_reg.cy, 1000);
        code_rem2_next          = 7'(dec_rem(13'(s1_job_reg.code), 100));
        cx_rem2_next            = 10'(dec_rem(s1_job_reg.cx, 1000));
        cy_rem2_next            = 10'(dec_rem(s1_job_reg.cy, 1000));
    end

    always_comb
    begin
        s3_job_next             = s2_job_reg;
        s3_job_next.code_dig[1] = dec_digit(13'(code_rem2_reg), 10);
        s3_job_next.code_dig[0] = 4'(dec_rem(13'(code_rem2_reg), 10));
        s3_job_next.cx_dig[2]   = dec_digit(13'(cx_rem2_reg), 100);
        s3_job_next.cy_dig[2]   = dec_digit(13'(cy_rem2_reg), 100);
        cx_rem3_next            = 7'(dec_rem(13'(cx_rem2_reg), 100));
        cy_rem3_next            = 7'(dec_rem(13'(cy_rem2_reg), 100));
    end

    always_comb
    begin
        s4_job_next           = s3_job_reg;
        s4_job_next.cx_dig[1] = dec_digit(13'(cx_rem3_reg), 10);
        s4_job_next.cx_dig[0] = 4'(dec_rem(13'(cx_rem3_reg), 10));
        s4_job_next.cy_dig[1] = dec_digit(13'(cy_rem3_reg), 10);
        s4_job_next.cy_dig[0] = 4'(dec_rem(13'(cy_rem3_reg), 10));
    end

    // Events taken while reporting is off are dropped here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= push && report_enable;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_job_reg    <= s1_job_next;
            s2_job_reg    <= s2_job_next;
            s3_job_reg    <= s3_job_next;
            s4_job_reg    <= s4_job_next;
            code_rem2_reg <= code_rem2_next;
            cx_rem2_reg   <= cx_rem2_next;
            cy_rem2_reg   <= cy_rem2_next;
            cx_rem3_reg   <= cx_rem3_next;
            cy_rem3_reg   <= cy_rem3_next;
        end
    end

endmodule

`default_nettype wire

[src/mre_queue.sv]
// Two-entry queue of converted reports between the front end and the byte emitter.
`default_nettype none

module mre_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    input  mre_pkg::job_t wr_job,
    output logic          q_full,
    output logic          q_empty,
    output mre_pkg::job_t head,
    input  logic          rd_pop
);
    import mre_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_wr, do_rd;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_valid && !q_full;
    assign do_rd   = rd_pop && !q_empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

`default_nettype wire

[src/mre_back.sv]
// Back end: walks through one report a byte at a time into the output register.
`default_nettype none

module mre_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  mre_pkg::job_t     head,
    output logic              q_pop,
    output logic              empty,
    input  logic              pop,
    output mre_pkg::out_item_t out_item
);
    import mre_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_BRACKET  = 4'd1;
    localparam logic [3:0] ST_LT       = 4'd2;
    localparam logic [3:0] ST_CODE     = 4'd3;
    localparam logic [3:0] ST_SEMI1    = 4'd4;
    localparam logic [3:0] ST_CX       = 4'd5;
    localparam logic [3:0] ST_SEMI2    = 4'd6;
    localparam logic [3:0] ST_CY       = 4'd7;
    localparam logic [3:0] ST_FINAL    = 4'd8;
    localparam logic [3:0] ST_LEG_M    = 4'd9;
    localparam logic [3:0] ST_LEG_CODE = 4'd10;
    localparam logic [3:0] ST_LEG_X    = 4'd11;
    localparam logic [3:0] ST_LEG_Y    = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    job_t       job_reg, job_next;
    out_item_t  out_reg, out_next;
    logic       out_valid_reg, out_valid_next;
    logic       adv;
    logic       emit;

    // A new byte can go out only when the output register is free or being taken.
    assign adv      = !out_valid_reg || pop;
    assign empty    = !out_valid_reg;
    assign out_item = out_reg;

    always_comb
    begin
        state_next         = state_reg;
        idx_next           = idx_reg;
        job_next           = job_reg;
        q_pop              = 1'b0;
        emit               = 1'b0;
        out_next.out_byte  = CH_ESC;
        out_next.last_byte = 1'b0;
        if (adv)
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        q_pop      = 1'b1;
                        job_next   = head;
                        emit       = 1'b1;
                        state_next = ST_BRACKET;
                    end
                end
                ST_BRACKET:
                begin
                    emit              = 1'b1;
                    out_next.out_byte = CH_LBRACK;
                    state_next        = job_reg.sgr ? ST_LT : ST_LEG_M;
                end
                ST_LT:
                begin
                    emit              = 1'b1;
                    out_next.out_byte = CH_LT;
                    idx_next          = top_digit(job_reg.code_dig);
                    state_next        = ST_CODE;
                end
                ST_CODE:
                begin
                    emit              = 1'b1;
                    out_next.out_byte = ascii_digit(job_reg.code_dig[idx_reg]);
                    idx_next          = idx_reg - 2'd1;
                    if (idx_reg == 2'd0)
                    begin
                        state_next = ST_SEMI1;
                    end
                end
                ST_SEMI1:
                begin
                    emit              = 1'b1;
                    out_next.out_byte = CH_SEMI;
                    idx_next          = top_digit(job_reg.cx_dig);
                    state_next        = ST_CX;
                end
                ST_CX:
                begin
                    emit              = 1'b1;
                    out_next.out_byte = ascii_digit(job_reg.cx_dig[idx_reg]);
                    idx_next          = idx_reg - 2'd1;
                    if (idx_reg == 2'd0)
                    begin
                        state_next = ST_SEMI2;
                    end
                end
                ST_SEMI2:
                begin
                    emit              = 1'b1;
                    out_next.out_byte = CH_SEMI;
                    idx_next          = top_digit(job_reg.cy_dig);
                    state_next        = ST_CY;
                end
                ST_CY:
                begin
                    emit              = 1'b1;
                    out_next.out_byte = ascii_digit(job_reg.cy_dig[idx_reg]);
                    idx_next          = idx_reg - 2'd1;
                    if (idx_reg == 2'd0)
                    begin
                        state_next = ST_FINAL;
                    end
                end
                ST_FINAL:
                begin
                    emit               = 1'b1;
                    out_next.out_byte  = job_reg.release_evt ? CH_M_LOW : CH_M_UP;
                    out_next.last_byte = 1'b1;
                    state_next         = ST_IDLE;
                end
                ST_LEG_M:
                begin
                    emit              = 1'b1;
                    out_next.out_byte = CH_M_UP;
                    state_next        = ST_LEG_CODE;
                end
                ST_LEG_CODE:
                begin
                    emit              = 1'b1;
                    out_next.out_byte = sat_byte(13'(job_reg.code));
                    state_next        = ST_LEG_X;
                end
                ST_LEG_X:
                begin
                    emit              = 1'b1;
                    out_next.out_byte = sat_byte(job_reg.cx);
                    state_next        = ST_LEG_Y;
                end
                ST_LEG_Y:
                begin
                    emit               = 1'b1;
                    out_next.out_byte  = sat_byte(job_reg.cy);
                    out_next.last_byte = 1'b1;
                    state_next         = ST_IDLE;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
        out_valid_next = adv ? emit : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        if (adv && emit)
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

[src/mre_checker.sv]
// Port-level checks on the report byte stream, bound to the top level.
`default_nettype none

module mre_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input mre_pkg::out_item_t out_item
);
    import mre_pkg::*;

    logic       at_start_reg;
    logic       after_esc_reg;
    logic [4:0] run_len_reg;

    // Track where in a report the shown byte sits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_start_reg  <= 1'b1;
            after_esc_reg <= 1'b0;
            run_len_reg   <= 5'd0;
        end
        else if (pop && !empty)
        begin
            at_start_reg  <= out_item.last_byte;
            after_esc_reg <= at_start_reg && !out_item.last_byte;
            run_len_reg   <= out_item.last_byte ? 5'd0 : run_len_reg + 5'd1;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(out_item))
        else $error("waiting byte changed or vanished while stalled");

    a_start_esc: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && at_start_reg |-> out_item.out_byte == CH_ESC && !out_item.last_byte)
        else $error("report does not open with ESC");

    a_bracket: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && after_esc_reg |-> out_item.out_byte == CH_LBRACK)
        else $error("ESC not followed by bracket");

    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> run_len_reg < 5'd17)
        else $error("report longer than 17 bytes");

endmodule

bind mouse_report_encoder_core mre_checker u_mre_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
);

`default_nettype wire
